// File: design/affl_pkg.sv
// ----------------------------------------------------------------------------
// affl_pkg
// Shared types and constants of the aligned first-fit free-list core.
// ----------------------------------------------------------------------------
package affl_pkg;

    // default capacity of the free-extent list
    localparam int DEF_MAX_FREE_EXTENTS = 16;

    // block size after reset
    localparam logic [31:0] RESET_BLOCK_SIZE = 32'h1000_0000;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FLAGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MTYPE = 2'd2;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // one free extent
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } ext_t;

    // broadcast command to the cell row
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT_UP,
        OP_SHIFT_DOWN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        ext_t     data;
    } cell_cmd_t;

endpackage

// File: design/affl_cell.sv
// ----------------------------------------------------------------------------
// affl_cell
// One slot of the extent row: holds an extent and loads, holds or takes
// the value of its left or right neighbor on a broadcast command.
// ----------------------------------------------------------------------------
module affl_cell #(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  affl_pkg::cell_cmd_t cmd,
    input  logic [IDX_W-1:0]    pos,
    input  affl_pkg::ext_t      left,
    input  affl_pkg::ext_t      right,
    output affl_pkg::ext_t      q
);
    import affl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    ext_t ext_reg;
    ext_t ext_next;

    // select the new content of this slot
    always_comb
    begin
        ext_next = ext_reg;
        unique case (cmd.op)
            OP_HOLD:
            begin
                ext_next = ext_reg;
            end
            OP_LOAD:
            begin
                if (MY_IDX == pos)
                begin
                    ext_next = cmd.data;
                end
            end
            OP_SHIFT_UP:
            begin
                if (MY_IDX == pos)
                begin
                    ext_next = cmd.data;
                end
                else if (MY_IDX > pos)
                begin
                    ext_next = left;
                end
            end
            OP_SHIFT_DOWN:
            begin
                if (MY_IDX >= pos)
                begin
                    ext_next = right;
                end
            end
            default:
            begin
                ext_next = ext_reg;
            end
        endcase
    end

    // slot zero comes out of reset holding the whole block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if (CELL_IDX == 0)
            begin
                ext_reg <= '{start: 32'd0, length: RESET_BLOCK_SIZE};
            end
            else
            begin
                ext_reg <= '0;
            end
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

    assign q = ext_reg;

endmodule

// File: design/aligned_first_fit_free_list_core.sv
// ----------------------------------------------------------------------------
// aligned_first_fit_free_list_core
// First-fit allocator with alignment and coalescing free over one block.
// ----------------------------------------------------------------------------
// The free extents live in a row of MAX_FREE_EXTENTS+1 cells kept in list
// order; a sequencer walks the row one cell per cycle and the cells insert or
// remove an entry by shifting the cells from the given position onward.
// An allocate beat walks the list with the fit check one cell behind and
// commits the first extent that fits; a flags or type mismatch goes straight
// to the result. A free beat takes a walk to find the insertion point, one
// shift, one merge walk over the grown list, and one undo shift when a full
// list forces the free to be dropped. The next beat is taken as soon as the
// previous result sits in the output register. Writing the block size
// register resets the list to one extent covering the whole block.
// ----------------------------------------------------------------------------
module aligned_first_fit_free_list_core #(
    parameter int MAX_FREE_EXTENTS = affl_pkg::DEF_MAX_FREE_EXTENTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [affl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [31:0]                    request_size,
    input  logic [4:0]                     alignment_log2,
    input  logic [31:0]                    type_mask,
    input  logic [7:0]                     need_flags,
    input  logic [31:0]                    release_offset,
    input  logic [31:0]                    release_size,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [31:0]                    alloc_offset,
    output logic [31:0]                    span_offset,
    output logic [31:0]                    span_size,
    output logic                           block_empty
);
    import affl_pkg::*;

    localparam int NCELL = MAX_FREE_EXTENTS + 1;
    localparam int IDX_W = $clog2(NCELL);
    localparam int CNT_W = $clog2(MAX_FREE_EXTENTS + 2);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_A_SCAN   = 8'b0000_0010,
        S_A_COMMIT = 8'b0000_0100,
        S_F_FIND   = 8'b0000_1000,
        S_F_INSERT = 8'b0001_0000,
        S_F_MERGE  = 8'b0010_0000,
        S_F_UNDO   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    // cell row
    ext_t             cell_q [NCELL];
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] cmd_pos;

    // control state
    state_t           state_reg,    state_next;
    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [CNT_W-1:0] rd_reg,       rd_next;
    logic [IDX_W-1:0] wr_reg,       wr_next;
    logic [IDX_W-1:0] pos_reg,      pos_next;
    logic             stg_v_reg,    stg_v_next;
    logic             out_valid_reg, out_valid_next;

    // configuration
    logic [31:0]      bsize_reg,    bsize_next;
    logic [7:0]       flags_reg,    flags_next;
    logic [4:0]       mtype_reg,    mtype_next;

    // beat operands and work registers
    logic [31:0]      req_reg,      req_next;
    logic [4:0]       sh_reg,       sh_next;
    logic [31:0]      ns_reg,       ns_next;
    logic [31:0]      nl_reg,       nl_next;
    ext_t             acc_reg,      acc_next;
    logic [IDX_W-1:0] stg_k_reg,    stg_k_next;
    logic [31:0]      stg_st_reg,   stg_st_next;
    logic [32:0]      stg_al_reg,   stg_al_next;
    logic [32:0]      stg_end_reg,  stg_end_next;
    logic [33:0]      sum_reg,      sum_next;

    // pending result and output register
    logic [1:0]       res_st_reg,   res_st_next;
    logic [31:0]      res_al_reg,   res_al_next;
    logic [31:0]      res_so_reg,   res_so_next;
    logic [31:0]      res_ss_reg,   res_ss_next;
    logic [1:0]       out_st_reg,   out_st_next;
    logic [31:0]      out_al_reg,   out_al_next;
    logic [31:0]      out_so_reg,   out_so_next;
    logic [31:0]      out_ss_reg,   out_ss_next;
    logic             out_em_reg,   out_em_next;

    // datapath
    ext_t             rd_ext;
    logic [32:0]      amask;
    logic [32:0]      al_calc;
    logic [32:0]      end_calc;
    logic [33:0]      stg_sum;
    logic             fit;
    logic [33:0]      new_len;
    logic [33:0]      span_sum;
    logic [32:0]      acc_end;
    logic [32:0]      merge_sum;
    logic [CNT_W-1:0] n_work;

    // row of cells, each wired to its neighbors; an end cell feeds itself back on its open side
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        ext_t left_in;
        ext_t right_in;
        if (i == 0)
        begin : g_first
            assign left_in = cell_q[i];
        end
        else
        begin : g_mid_l
            assign left_in = cell_q[i-1];
        end
        if (i == NCELL - 1)
        begin : g_last
            assign right_in = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_q[i+1];
        end
        affl_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .pos   (cmd_pos),
            .left  (left_in),
            .right (right_in),
            .q     (cell_q[i])
        );
    end

    // walk read port
    assign rd_ext = cell_q[rd_reg[IDX_W-1:0]];

    // fit check, first half: aligned start and extent end
    assign amask    = (33'd1 << sh_reg) - 33'd1;
    assign al_calc  = ({1'b0, rd_ext.start} + amask) & ~amask;
    assign end_calc = {1'b0, rd_ext.start} + {1'b0, rd_ext.length};

    // fit check, second half: aligned end against extent end
    assign stg_sum  = {1'b0, stg_al_reg} + {2'b00, req_reg};
    assign fit      = stg_sum <= {1'b0, stg_end_reg};

    // commit arithmetic
    assign new_len  = {1'b0, stg_end_reg} - sum_reg;
    assign span_sum = sum_reg - {2'b00, stg_st_reg};

    // merge step
    assign acc_end   = {1'b0, acc_reg.start} + {1'b0, acc_reg.length};
    assign merge_sum = {1'b0, acc_reg.length} + {1'b0, rd_ext.length};
    assign n_work    = cnt_reg + CNT_W'(1);

    assign in_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        pos_next       = pos_reg;
        stg_v_next     = stg_v_reg;
        out_valid_next = out_valid_reg;
        bsize_next     = bsize_reg;
        flags_next     = flags_reg;
        mtype_next     = mtype_reg;
        req_next       = req_reg;
        sh_next        = sh_reg;
        ns_next        = ns_reg;
        nl_next        = nl_reg;
        acc_next       = acc_reg;
        stg_k_next     = stg_k_reg;
        stg_st_next    = stg_st_reg;
        stg_al_next    = stg_al_reg;
        stg_end_next   = stg_end_reg;
        sum_next       = sum_reg;
        res_st_next    = res_st_reg;
        res_al_next    = res_al_reg;
        res_so_next    = res_so_reg;
        res_ss_next    = res_ss_reg;
        out_st_next    = out_st_reg;
        out_al_next    = out_al_reg;
        out_so_next    = out_so_reg;
        out_ss_next    = out_ss_reg;
        out_em_next    = out_em_reg;
        cmd.op         = OP_HOLD;
        cmd.data       = '0;
        cmd_pos        = '0;

        // result beat leaves
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_SIZE:
                begin
                    bsize_next = cfg_data;
                    cmd.op     = OP_LOAD;
                    cmd.data   = '{start: 32'd0, length: cfg_data};
                    cmd_pos    = '0;
                    cnt_next   = CNT_W'(1);
                end
                REG_BLOCK_FLAGS:
                begin
                    flags_next = cfg_data[7:0];
                end
                REG_BLOCK_MTYPE:
                begin
                    mtype_next = cfg_data[4:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = request_size;
                    sh_next     = alignment_log2;
                    ns_next     = release_offset;
                    nl_next     = release_size;
                    rd_next     = '0;
                    stg_v_next  = 1'b0;
                    res_st_next = ST_OK;
                    res_al_next = '0;
                    res_so_next = '0;
                    res_ss_next = '0;
                    if (func == FUNC_FREE)
                    begin
                        state_next = S_F_FIND;
                    end
                    else if (((flags_reg & need_flags) != need_flags) ||
                             !type_mask[mtype_reg])
                    begin
                        res_st_next = ST_MISMATCH;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A_SCAN;
                    end
                end
            end

            // first-fit walk, check pipelined one cell behind the read
            S_A_SCAN:
            begin
                if (stg_v_reg && fit)
                begin
                    sum_next   = stg_sum;
                    state_next = S_A_COMMIT;
                end
                else if (rd_reg < cnt_reg)
                begin
                    stg_v_next   = 1'b1;
                    stg_k_next   = rd_reg[IDX_W-1:0];
                    stg_st_next  = rd_ext.start;
                    stg_al_next  = al_calc;
                    stg_end_next = end_calc;
                    rd_next      = rd_reg + CNT_W'(1);
                end
                else
                begin
                    res_st_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end
            end

            // shrink the chosen extent or drop it when used up
            S_A_COMMIT:
            begin
                if (new_len[31:0] == 32'd0)
                begin
                    cmd.op   = OP_SHIFT_DOWN;
                    cmd_pos  = stg_k_reg;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    cmd.op   = OP_LOAD;
                    cmd.data = '{start: sum_reg[31:0], length: new_len[31:0]};
                    cmd_pos  = stg_k_reg;
                end
                res_al_next = stg_al_reg[31:0];
                res_so_next = stg_st_reg;
                res_ss_next = span_sum[31:0];
                state_next  = S_DONE;
            end

            // find the first extent that starts past the start of the freed span
            S_F_FIND:
            begin
                if (rd_reg < cnt_reg)
                begin
                    if (rd_ext.start > ns_reg)
                    begin
                        pos_next   = rd_reg[IDX_W-1:0];
                        state_next = S_F_INSERT;
                    end
                    else
                    begin
                        rd_next = rd_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    pos_next   = rd_reg[IDX_W-1:0];
                    state_next = S_F_INSERT;
                end
            end

            // open a slot and seed the merge accumulator
            S_F_INSERT:
            begin
                cmd.op   = OP_SHIFT_UP;
                cmd.data = '{start: ns_reg, length: nl_reg};
                cmd_pos  = pos_reg;
                if (pos_reg == '0)
                begin
                    acc_next = '{start: ns_reg, length: nl_reg};
                end
                else
                begin
                    acc_next = cell_q[0];
                end
                rd_next    = CNT_W'(1);
                wr_next    = '0;
                state_next = S_F_MERGE;
            end

            // coalescing walk, compacting in place
            S_F_MERGE:
            begin
                cmd.op   = OP_LOAD;
                cmd.data = acc_reg;
                cmd_pos  = wr_reg;
                if (rd_reg < n_work)
                begin
                    if (acc_end == {1'b0, rd_ext.start})
                    begin
                        cmd.op         = OP_HOLD;
                        acc_next.length = merge_sum[32] ? 32'hFFFF_FFFF : merge_sum[31:0];
                    end
                    else
                    begin
                        wr_next  = wr_reg + IDX_W'(1);
                        acc_next = rd_ext;
                    end
                    rd_next = rd_reg + CNT_W'(1);
                end
                else if (wr_reg == IDX_W'(MAX_FREE_EXTENTS))
                begin
                    state_next = S_F_UNDO;
                end
                else
                begin
                    cnt_next   = CNT_W'(wr_reg) + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            // list overflow: take the inserted extent back out
            S_F_UNDO:
            begin
                cmd.op      = OP_SHIFT_DOWN;
                cmd_pos     = pos_reg;
                res_st_next = ST_FULL;
                state_next  = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_st_next    = res_st_reg;
                    out_al_next    = res_al_reg;
                    out_so_next    = res_so_reg;
                    out_ss_next    = res_ss_reg;
                    out_em_next    = (cnt_reg == CNT_W'(1)) &&
                                     (cell_q[0].length == bsize_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CNT_W'(1);
            rd_reg        <= '0;
            wr_reg        <= '0;
            pos_reg       <= '0;
            stg_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bsize_reg     <= RESET_BLOCK_SIZE;
            flags_reg     <= '0;
            mtype_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            pos_reg       <= pos_next;
            stg_v_reg     <= stg_v_next;
            out_valid_reg <= out_valid_next;
            bsize_reg     <= bsize_next;
            flags_reg     <= flags_next;
            mtype_reg     <= mtype_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        sh_reg      <= sh_next;
        ns_reg      <= ns_next;
        nl_reg      <= nl_next;
        acc_reg     <= acc_next;
        stg_k_reg   <= stg_k_next;
        stg_st_reg  <= stg_st_next;
        stg_al_reg  <= stg_al_next;
        stg_end_reg <= stg_end_next;
        sum_reg     <= sum_next;
        res_st_reg  <= res_st_next;
        res_al_reg  <= res_al_next;
        res_so_reg  <= res_so_next;
        res_ss_reg  <= res_ss_next;
        out_st_reg  <= out_st_next;
        out_al_reg  <= out_al_next;
        out_so_reg  <= out_so_next;
        out_ss_reg  <= out_ss_next;
        out_em_reg  <= out_em_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign alloc_offset   = out_al_reg;
    assign span_offset    = out_so_reg;
    assign span_size      = out_ss_reg;
    assign block_empty    = out_em_reg;

    // list never holds more extents than its capacity between beats
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_F_MERGE) |-> (cnt_reg <= CNT_W'(MAX_FREE_EXTENTS)))
        else $error("extent count above capacity");

    // a free is only dropped when the list is already full
    a_undo_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F_UNDO) |-> (cnt_reg == CNT_W'(MAX_FREE_EXTENTS)))
        else $error("free dropped on a list that is not full");

    // a commit always follows a checked extent in the fit stage
    a_commit_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_COMMIT) |-> ($past(state_reg) == S_A_SCAN) && stg_v_reg)
        else $error("commit without a checked extent");

endmodule
